FILE: design/dalq_pkg.sv
`default_nettype none

package dalq_pkg;

   // table geometry
   localparam int CAPACITY   = 32;
   localparam int OWNER_BITS = 8;
   localparam int MAX_OUT    = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(MAX_OUT + 1);

   // field widths
   localparam int TIME_W        = 32;
   localparam int ALARM_W       = 3;
   localparam int ACTION_W      = 2;
   localparam int KIND_W        = 3;
   localparam int OWNER_FIELD_W = 8;
   localparam int REQ_DATA_W    = 80;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_REGISTER   = 2'd0,
      ACT_DEREGISTER = 2'd1,
      ACT_TICK       = 2'd2,
      ACT_RESERVED   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OK        = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_NOT_FOUND = 3'd2,
      KIND_FIRED     = 3'd3,
      KIND_NONE      = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

   // one stored alarm
   typedef struct packed {
      logic [TIME_W-1:0]     deadline;
      logic [TIME_W-1:0]     stamp;
      logic [OWNER_BITS-1:0] owner;
      logic [ALARM_W-1:0]    alarm;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controls from the sequencer to the scan unit
   typedef struct packed {
      logic                  clear;
      logic                  sample;
      logic                  tick;
      logic [IDX_W-1:0]      idx;
      logic                  valid;
      logic [OWNER_BITS-1:0] owner;
      logic [ALARM_W-1:0]    alarm;
      logic [TIME_W-1:0]     now;
      logic [TIME_W-1:0]     counter;
   } scan_ctl_type;

   // what one pass over the table found
   typedef struct packed {
      logic                  match_found;
      logic [IDX_W-1:0]      match_idx;
      logic                  free_found;
      logic [IDX_W-1:0]      free_idx;
      logic                  best_found;
      logic [IDX_W-1:0]      best_idx;
      logic [OWNER_BITS-1:0] best_owner;
      logic [ALARM_W-1:0]    best_alarm;
   } scan_res_type;

endpackage

`default_nettype wire

FILE: design/deadline_alarm_queue_unit.sv
`default_nettype none

// Alarm queue holding up to CAPACITY pending alarms (owner, alarm number,
// 32-bit deadline) in a single-port-read entry memory, with valid bits in
// flip-flops so the table is empty straight after reset. The block takes one
// request beat at a time. Register and deregister each read every entry once
// and then answer. A tick runs one pass over the table per fired alarm plus
// one final pass that finds nothing more due; a tick that fires the full 32
// skips the final pass and ends in the flush state instead. Each pass reads
// one entry per cycle through the memory read port. Fired alarms come out in
// deadline order, oldest insertion first on equal deadlines, with tlast on
// the final beat; a tick that fires nothing returns one beat of kind none.
// Each result sits in an output register, so the next request is taken
// while the last result still waits; a stalled result stalls the sequencer.
module deadline_alarm_queue_unit
   import dalq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // owner_id [7:0], alarm_number [10:8], deadline [42:11], now [74:43]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action [1:0]
   input  wire logic [ACTION_W-1:0]   req_tuser,
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // fired_owner [7:0], fired_alarm [10:8]
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // kind [2:0]
   output logic      [KIND_W-1:0]     rsp_tuser,
   output logic                       rsp_tlast
);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] LAST_FIRE = CNT_W'(MAX_OUT - 1);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  smp_ff, smp_in;
   logic [IDX_W-1:0]      smp_idx_ff, smp_idx_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [TIME_W-1:0]     counter_ff, counter_in;

   action_type            act_ff, act_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [ALARM_W-1:0]    alarm_ff, alarm_in;
   logic [TIME_W-1:0]     deadline_ff, deadline_in;
   logic [TIME_W-1:0]     now_ff, now_in;

   logic                  pend_ff, pend_in;
   logic [OWNER_BITS-1:0] pend_owner_ff, pend_owner_in;
   logic [ALARM_W-1:0]    pend_alarm_ff, pend_alarm_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [OWNER_BITS-1:0] rsp_owner_ff, rsp_owner_in;
   logic [ALARM_W-1:0]    rsp_alarm_ff, rsp_alarm_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  accept;
   logic                  scan_clear;
   logic                  emit;
   kind_type              emit_kind;
   logic [OWNER_BITS-1:0] emit_owner;
   logic [ALARM_W-1:0]    emit_alarm;
   logic                  emit_last;
   logic [IDX_W-1:0]      slot;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   entry_type             ram_wdata;
   logic                  ram_re;
   entry_type             ram_rdata;

   scan_ctl_type          scan_ctl;
   scan_res_type          scan_res;

   // entry memory
   dalq_entry_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // scan unit sees each entry in the cycle after its read
   assign scan_ctl.clear   = scan_clear;
   assign scan_ctl.sample  = smp_ff;
   assign scan_ctl.tick    = (act_ff == ACT_TICK);
   assign scan_ctl.idx     = smp_idx_ff;
   assign scan_ctl.valid   = valid_ff[smp_idx_ff];
   assign scan_ctl.owner   = owner_ff;
   assign scan_ctl.alarm   = alarm_ff;
   assign scan_ctl.now     = now_ff;
   assign scan_ctl.counter = counter_ff;

   dalq_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (ram_rdata),
      .res     (scan_res)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // sequencer: next state, memory access and result beats
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      smp_in        = 1'b0;
      smp_idx_in    = addr_ff;
      valid_in      = valid_ff;
      counter_in    = counter_ff;
      act_in        = act_ff;
      owner_in      = owner_ff;
      alarm_in      = alarm_ff;
      deadline_in   = deadline_ff;
      now_in        = now_ff;
      pend_in       = pend_ff;
      pend_owner_in = pend_owner_ff;
      pend_alarm_in = pend_alarm_ff;
      count_in      = count_ff;
      scan_clear    = 1'b0;
      ram_re        = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = scan_res.match_idx;
      ram_wdata     = '0;
      emit          = 1'b0;
      emit_kind     = KIND_OK;
      emit_owner    = '0;
      emit_alarm    = '0;
      emit_last     = 1'b1;
      slot          = scan_res.match_found ? scan_res.match_idx : scan_res.free_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in      = action_type'(req_tuser);
               owner_in    = OWNER_BITS'(req_tdata[7:0]);
               alarm_in    = req_tdata[10:8];
               deadline_in = req_tdata[42:11];
               now_in      = req_tdata[74:43];
               pend_in     = 1'b0;
               count_in    = '0;
               if (action_type'(req_tuser) != ACT_RESERVED) begin
                  state_in   = ST_SCAN;
                  addr_in    = '0;
                  scan_clear = 1'b1;
               end
            end
         end

         ST_SCAN: begin
            // read one entry per cycle
            ram_re     = 1'b1;
            smp_in     = 1'b1;
            smp_idx_in = addr_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (out_free) begin
               unique case (act_ff)
                  ACT_REGISTER: begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (scan_res.match_found || scan_res.free_found) begin
                        ram_we             = 1'b1;
                        ram_waddr          = slot;
                        ram_wdata.deadline = deadline_ff;
                        ram_wdata.stamp    = counter_ff;
                        ram_wdata.owner    = owner_ff;
                        ram_wdata.alarm    = alarm_ff;
                        valid_in[slot]     = 1'b1;
                        counter_in         = counter_ff + 1'b1;
                        emit_kind          = KIND_OK;
                     end else begin
                        emit_kind = KIND_FULL;
                     end
                  end

                  ACT_DEREGISTER: begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (scan_res.match_found) begin
                        valid_in[scan_res.match_idx] = 1'b0;
                        emit_kind                    = KIND_OK;
                     end else begin
                        emit_kind = KIND_NOT_FOUND;
                     end
                  end

                  ACT_TICK: begin
                     if (scan_res.best_found) begin
                        // retire the alarm; send the one held from the pass before
                        valid_in[scan_res.best_idx] = 1'b0;
                        if (pend_ff) begin
                           emit       = 1'b1;
                           emit_kind  = KIND_FIRED;
                           emit_owner = pend_owner_ff;
                           emit_alarm = pend_alarm_ff;
                           emit_last  = 1'b0;
                        end
                        pend_in       = 1'b1;
                        pend_owner_in = scan_res.best_owner;
                        pend_alarm_in = scan_res.best_alarm;
                        count_in      = count_ff + 1'b1;
                        if (count_ff == LAST_FIRE) begin
                           state_in = ST_FLUSH;
                        end else begin
                           state_in   = ST_SCAN;
                           addr_in    = '0;
                           scan_clear = 1'b1;
                        end
                     end else begin
                        // nothing more due: close the run
                        emit     = 1'b1;
                        state_in = ST_IDLE;
                        if (pend_ff) begin
                           emit_kind  = KIND_FIRED;
                           emit_owner = pend_owner_ff;
                           emit_alarm = pend_alarm_ff;
                        end else begin
                           emit_kind = KIND_NONE;
                        end
                     end
                  end

                  ACT_RESERVED: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_FIRED;
               emit_owner = pend_owner_ff;
               emit_alarm = pend_alarm_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_owner_in = rsp_owner_ff;
      rsp_alarm_in = rsp_alarm_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_owner_in = emit_owner;
         rsp_alarm_in = emit_alarm;
         rsp_last_in  = emit_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         smp_ff       <= 1'b0;
         valid_ff     <= '0;
         counter_ff   <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smp_ff       <= smp_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      smp_idx_ff    <= smp_idx_in;
      act_ff        <= act_in;
      owner_ff      <= owner_in;
      alarm_ff      <= alarm_in;
      deadline_ff   <= deadline_in;
      now_ff        <= now_in;
      pend_owner_ff <= pend_owner_in;
      pend_alarm_ff <= pend_alarm_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - OWNER_FIELD_W - ALARM_W){1'b0}},
                        rsp_alarm_ff, OWNER_FIELD_W'(rsp_owner_ff)};

endmodule

`default_nettype wire

FILE: design/dalq_entry_ram.sv
`default_nettype none

module dalq_entry_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 75
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/dalq_scan.sv
`default_nettype none

module dalq_scan
   import dalq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_ctl_type ctl,
   input  wire entry_type    rd_data,
   output scan_res_type      res
);

   logic                  match_found_ff, match_found_in;
   logic [IDX_W-1:0]      match_idx_ff, match_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]     best_deadline_ff, best_deadline_in;
   logic [TIME_W-1:0]     best_age_ff, best_age_in;
   logic [OWNER_BITS-1:0] best_owner_ff, best_owner_in;
   logic [ALARM_W-1:0]    best_alarm_ff, best_alarm_in;

   logic [TIME_W-1:0] age;
   logic              due;
   logic              better;
   logic              hit;

   // compare the entry just read against the running result
   always_comb begin
      age    = ctl.counter - rd_data.stamp;
      due    = ctl.valid && (rd_data.deadline <= ctl.now);
      better = !best_found_ff || (rd_data.deadline < best_deadline_ff) ||
               ((rd_data.deadline == best_deadline_ff) && (age > best_age_ff));
      hit    = ctl.valid && (rd_data.owner == ctl.owner) && (rd_data.alarm == ctl.alarm);

      match_found_in   = match_found_ff;
      match_idx_in     = match_idx_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      best_found_in    = best_found_ff;
      best_idx_in      = best_idx_ff;
      best_deadline_in = best_deadline_ff;
      best_age_in      = best_age_ff;
      best_owner_in    = best_owner_ff;
      best_alarm_in    = best_alarm_ff;

      if (ctl.clear) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
      end else if (ctl.sample) begin
         if (ctl.tick) begin
            // keep the earliest due alarm, oldest first on a tie
            if (due && better) begin
               best_found_in    = 1'b1;
               best_idx_in      = ctl.idx;
               best_deadline_in = rd_data.deadline;
               best_age_in      = age;
               best_owner_in    = rd_data.owner;
               best_alarm_in    = rd_data.alarm;
            end
         end else begin
            // first matching entry and first free entry
            if (hit && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = ctl.idx;
            end
            if (!ctl.valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = ctl.idx;
            end
         end
      end
   end

   // hold the flags
   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
      end
   end

   // hold the payload
   always_ff @(posedge clock) begin
      match_idx_ff     <= match_idx_in;
      free_idx_ff      <= free_idx_in;
      best_idx_ff      <= best_idx_in;
      best_deadline_ff <= best_deadline_in;
      best_age_ff      <= best_age_in;
      best_owner_ff    <= best_owner_in;
      best_alarm_ff    <= best_alarm_in;
   end

   assign res.match_found = match_found_ff;
   assign res.match_idx   = match_idx_ff;
   assign res.free_found  = free_found_ff;
   assign res.free_idx    = free_idx_ff;
   assign res.best_found  = best_found_ff;
   assign res.best_idx    = best_idx_ff;
   assign res.best_owner  = best_owner_ff;
   assign res.best_alarm  = best_alarm_ff;

endmodule

`default_nettype wire

FILE: tb/dalq_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the alarm queue, keeps its own
// copy of the alarm table and checks every result beat against it.
module dalq_checker
   import dalq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // owner_id [7:0], alarm_number [10:8], deadline [42:11], now [74:43]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action [1:0]
   input  wire logic [ACTION_W-1:0]   req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // fired_owner [7:0], fired_alarm [10:8]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind [2:0]
   input  wire logic [KIND_W-1:0]     rsp_tuser,
   input  wire logic                  rsp_tlast,
   output int                         fail_count,
   output int                         results_owed
);

   typedef struct {
      kind_type   kind;
      logic [7:0] owner;
      logic [2:0] alarm;
      logic       last;
   } outcome_type;

   // results still owed by the block, oldest first
   outcome_type pending_outcomes[$];

   // shadow alarm table
   logic                  slot_used     [CAPACITY];
   logic [TIME_W-1:0]     slot_deadline [CAPACITY];
   logic [TIME_W-1:0]     slot_stamp    [CAPACITY];
   logic [OWNER_BITS-1:0] slot_owner    [CAPACITY];
   logic [ALARM_W-1:0]    slot_alarm    [CAPACITY];
   logic [TIME_W-1:0]     insert_seq;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      fail_count++;
   endtask

   task automatic owe_outcome(input kind_type k, input logic [7:0] o,
                              input logic [2:0] a, input logic l);
      outcome_type b;
      b.kind  = k;
      b.owner = o;
      b.alarm = a;
      b.last  = l;
      pending_outcomes.push_back(b);
   endtask

   function automatic int find_alarm(input logic [OWNER_BITS-1:0] o,
                                     input logic [ALARM_W-1:0] a);
      int i;
      find_alarm = -1;
      for (i = CAPACITY - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_owner[i] == o && slot_alarm[i] == a) begin
            find_alarm = i;
         end
      end
   endfunction

   // update the shadow table for one request beat and queue its results
   task automatic apply_request(input action_type act, input logic [7:0] own,
                                input logic [2:0] alm, input logic [31:0] due,
                                input logic [31:0] now_ticks);
      logic [OWNER_BITS-1:0] key_owner;
      int                    slot;
      int                    best;
      int                    i;
      int                    fired;
      logic                  searching;
      logic [TIME_W-1:0]     age;
      logic [TIME_W-1:0]     best_age;
      outcome_type           held;
      key_owner = OWNER_BITS'(own);
      best_age  = '0;
      held      = '{KIND_FIRED, 8'd0, 3'd0, 1'b0};
      case (act)
         ACT_REGISTER: begin
            slot = find_alarm(key_owner, alm);
            if (slot < 0) begin
               for (i = CAPACITY - 1; i >= 0; i--) begin
                  if (!slot_used[i]) slot = i;
               end
            end
            if (slot < 0) begin
               owe_outcome(KIND_FULL, 8'd0, 3'd0, 1'b1);
            end else begin
               slot_used[slot]     = 1'b1;
               slot_owner[slot]    = key_owner;
               slot_alarm[slot]    = alm;
               slot_deadline[slot] = due;
               slot_stamp[slot]    = insert_seq;
               insert_seq          = insert_seq + 1;
               owe_outcome(KIND_OK, 8'd0, 3'd0, 1'b1);
            end
         end
         ACT_DEREGISTER: begin
            slot = find_alarm(key_owner, alm);
            if (slot < 0) begin
               owe_outcome(KIND_NOT_FOUND, 8'd0, 3'd0, 1'b1);
            end else begin
               slot_used[slot] = 1'b0;
               owe_outcome(KIND_OK, 8'd0, 3'd0, 1'b1);
            end
         end
         ACT_TICK: begin
            // fire earliest deadline first, oldest insertion on a tie;
            // hold each fired beat back until we know whether it is the last
            fired     = 0;
            searching = 1'b1;
            while (searching && fired < MAX_OUT) begin
               best = -1;
               for (i = 0; i < CAPACITY; i++) begin
                  if (slot_used[i] && slot_deadline[i] <= now_ticks) begin
                     age = insert_seq - slot_stamp[i];
                     if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                         (slot_deadline[i] == slot_deadline[best] && age > best_age)) begin
                        best     = i;
                        best_age = age;
                     end
                  end
               end
               if (best < 0) begin
                  searching = 1'b0;
               end else begin
                  slot_used[best] = 1'b0;
                  if (fired > 0) pending_outcomes.push_back(held);
                  held = '{KIND_FIRED, 8'(slot_owner[best]), slot_alarm[best], 1'b0};
                  fired++;
               end
            end
            if (fired == 0) begin
               owe_outcome(KIND_NONE, 8'd0, 3'd0, 1'b1);
            end else begin
               held.last = 1'b1;
               pending_outcomes.push_back(held);
            end
         end
         default: begin
         end
      endcase
   endtask

   // compare result beats first, so a beat never meets expectations of the
   // request taken at the same edge
   always @(posedge clock) begin
      outcome_type want;
      int          i;
      if (reset) begin
         for (i = 0; i < CAPACITY; i++) begin
            slot_used[i]     = 1'b0;
            slot_deadline[i] = '0;
            slot_stamp[i]    = '0;
            slot_owner[i]    = '0;
            slot_alarm[i]    = '0;
         end
         insert_seq = '0;
         pending_outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing owed: kind %0d owner %0d alarm %0d last %0b",
                                         rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tlast));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.owner ||
                   rsp_tdata[10:8] !== want.alarm || rsp_tlast !== want.last) begin
                  report_mismatch($sformatf({"kind %0d/%0d owner %0d/%0d alarm %0d/%0d",
                                             " last %0b/%0b (got/want)"},
                                            rsp_tuser, want.kind, rsp_tdata[7:0], want.owner,
                                            rsp_tdata[10:8], want.alarm, rsp_tlast, want.last));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(action_type'(req_tuser), req_tdata[7:0], req_tdata[10:8],
                          req_tdata[42:11], req_tdata[74:43]);
         end
      end
      results_owed = pending_outcomes.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import dalq_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_REQUESTS = 70;
   localparam int FILL_COUNT = CAPACITY + 2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = ACT_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   int                    fail_count;
   int                    results_owed;
   int                    sender_idle_pct = 24;
   int                    receiver_idle_pct = 79;
   int                    requests_sent = 0;
   int                    quiet_cycles = 0;
   logic [31:0]           wall_ticks = '0;
   logic [7:0]            owner_pool [6];

   always #2 clock = ~clock;

   deadline_alarm_queue_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dalq_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // stall the result channel at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // present one request beat, with a random gap first, and hold it until taken
   task automatic send_request(input action_type act, input logic [7:0] own,
                               input logic [2:0] alm, input logic [31:0] due,
                               input logic [31:0] now_ticks);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_DATA_W - 75){1'b0}}, now_ticks, due, alm, own};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act != ACT_RESERVED) requests_sent++;
      @(negedge clock);
   endtask

   // fill the table past capacity with near-equal deadlines, then fire all
   task automatic fill_table();
      logic [7:0]  base;
      logic [31:0] due_base;
      int          i;
      base     = 8'($urandom);
      due_base = wall_ticks;
      for (i = 0; i < FILL_COUNT; i++) begin
         send_request(ACT_REGISTER, base + 8'(i), 3'($urandom),
                      due_base + 32'($urandom_range(3)), $urandom);
      end
      send_request(ACT_TICK, 8'($urandom), 3'($urandom), $urandom, 32'hFFFF_FFFF);
   endtask

   // mostly well-formed traffic on a small set of alarms, with some noise
   task automatic random_request();
      int          pick;
      logic [7:0]  own;
      logic [2:0]  alm;
      logic [31:0] due;
      pick = $urandom_range(99);
      own  = ($urandom_range(3) == 0) ? 8'($urandom) : owner_pool[$urandom_range(5)];
      alm  = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if (pick < 40) begin
         due = ($urandom_range(9) == 0) ? $urandom : wall_ticks + 32'($urandom_range(30));
         send_request(ACT_REGISTER, own, alm, due, $urandom);
      end else if (pick < 58) begin
         send_request(ACT_DEREGISTER, own, alm, $urandom, $urandom);
      end else if (pick < 82) begin
         wall_ticks = wall_ticks + 32'($urandom_range(15));
         send_request(ACT_TICK, 8'($urandom), 3'($urandom), $urandom, wall_ticks);
      end else if (pick < 86) begin
         send_request(ACT_TICK, 8'($urandom), 3'($urandom), $urandom, 32'hFFFF_FFFF);
      end else if (pick < 96) begin
         send_request(action_type'(2'($urandom_range(2))), 8'($urandom), 3'($urandom),
                      $urandom, $urandom);
      end else begin
         send_request(ACT_RESERVED, 8'($urandom), 3'($urandom), $urandom, $urandom);
      end
   endtask

   initial begin
      int phase;
      int quota;
      owner_pool[0] = 8'h00;
      owner_pool[1] = 8'hFF;
      for (phase = 2; phase < 6; phase++) owner_pool[phase] = 8'($urandom);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty table, missing alarm
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'h0);
      send_request(ACT_DEREGISTER, 8'h3C, 3'd1, 32'h0, 32'h0);
      // extremes, tie on deadline, re-registration moves to newest
      send_request(ACT_REGISTER, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'h0);
      send_request(ACT_REGISTER, 8'h00, 3'd0, 32'h0, 32'hFFFF_FFFF);
      send_request(ACT_REGISTER, 8'h55, 3'd5, 32'd100, 32'h0);
      send_request(ACT_REGISTER, 8'hAA, 3'd2, 32'd100, 32'h0);
      send_request(ACT_REGISTER, 8'h55, 3'd5, 32'd100, 32'h0);
      // deregister hit, then miss
      send_request(ACT_REGISTER, 8'h12, 3'd6, 32'd50, 32'h0);
      send_request(ACT_DEREGISTER, 8'h12, 3'd6, 32'h0, 32'h0);
      send_request(ACT_DEREGISTER, 8'h12, 3'd6, 32'h0, 32'h0);
      // ignored action
      send_request(ACT_RESERVED, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // fire up to a boundary, then the tied pair
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'd99);
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'd100);
      // deadlines either side of the sign bit
      send_request(ACT_REGISTER, 8'h0F, 3'd3, 32'h8000_0000, 32'h0);
      send_request(ACT_REGISTER, 8'hF0, 3'd4, 32'h7FFF_FFFF, 32'h0);
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'h7FFF_FFFF);
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'hFFFF_FFFF);
      send_request(ACT_TICK, 8'h00, 3'd0, 32'h0, 32'hFFFF_FFFF);

      // random traffic under three idling patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 24;
               receiver_idle_pct = 79;
               wall_ticks        = $urandom;
            end
            1: begin
               sender_idle_pct   = 79;
               receiver_idle_pct = 24;
               wall_ticks        = 32'hFFFF_FF00;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               wall_ticks        = 32'($urandom_range(1000));
            end
         endcase
         quota = requests_sent + PHASE_REQUESTS;
         fill_table();
         while (requests_sent < quota) random_request();
      end
      req_tvalid <= 1'b0;

      // drain the owed results, then allow the tail of the last pass
      do @(negedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
